>>> sv/jjy_time_code_frame_encoder_top_macros.svh
// ----------------------------------------------------------------------------
// jjy time-code encoder assertion macros
// concurrent assertion wrappers shared by the port checker
// ----------------------------------------------------------------------------
`ifndef JJY_TIME_CODE_FRAME_ENCODER_TOP_MACROS_SVH
`define JJY_TIME_CODE_FRAME_ENCODER_TOP_MACROS_SVH

// checked only while out of reset
`define JJYTCE_ASSERT_ON(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// checked on every edge, reset included
`define JJYTCE_ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) (expr)) else $error(msg);

`endif

>>> sv/jjytce_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jjy time-code encoder package
// item types, queue structs, symbol codes and calendar helper functions
// ----------------------------------------------------------------------------
package jjytce_pkg;

  localparam int FRAME_LEN = 60;
  localparam logic [5:0] LAST_SEC = 6'd59;

  typedef logic [FRAME_LEN-1:0] frame_t;

  // marker seconds: 0, 9, 19, 29, 39, 49, 59
  localparam frame_t MARKER_MASK = (frame_t'(1) << 0)  | (frame_t'(1) << 9)  |
                                   (frame_t'(1) << 19) | (frame_t'(1) << 29) |
                                   (frame_t'(1) << 39) | (frame_t'(1) << 49) |
                                   (frame_t'(1) << 59);

  localparam logic [1:0] SYM_MARKER = 2'd0;
  localparam logic [1:0] SYM_ZERO   = 2'd1;
  localparam logic [1:0] SYM_ONE    = 2'd2;

  localparam logic [9:0] HT_MARKER = 10'd200;
  localparam logic [9:0] HT_ZERO   = 10'd800;
  localparam logic [9:0] HT_ONE    = 10'd500;

  typedef struct packed {
    logic [13:0] cal_year;
    logic [3:0]  cal_month;
    logic [4:0]  cal_day;
    logic [4:0]  clock_hour;
    logic [5:0]  clock_minute;
  } in_item_t;

  typedef struct packed {
    logic [1:0] symbol;
    logic [5:0] second_index;
    logic [9:0] high_time_ms;
    logic       frame_last;
  } out_item_t;

  // front to queue
  typedef struct packed {
    logic   push;
    frame_t bits;
  } q_wr_t;

  // queue to back
  typedef struct packed {
    logic   avail;
    frame_t bits;
  } q_rd_t;

  // (153 * m + 2) / 5 for the march-based month index
  function automatic logic [8:0] month_term(input logic [3:0] ma);
    logic [8:0] t;
    case (ma)
      4'd0:    t = 9'd0;
      4'd1:    t = 9'd31;
      4'd2:    t = 9'd61;
      4'd3:    t = 9'd92;
      4'd4:    t = 9'd122;
      4'd5:    t = 9'd153;
      4'd6:    t = 9'd184;
      4'd7:    t = 9'd214;
      4'd8:    t = 9'd245;
      4'd9:    t = 9'd275;
      4'd10:   t = 9'd306;
      4'd11:   t = 9'd337;
      4'd12:   t = 9'd367;
      default: t = 9'd0;
    endcase
    return t;
  endfunction

  // shift-and-add-3 binary to three bcd digits
  function automatic logic [11:0] bin_to_bcd(input logic [8:0] bin);
    logic [11:0] bcd;
    bcd = '0;
    for (int i = 8; i >= 0; i--) begin
      if (bcd[3:0] >= 4'd5)  bcd[3:0]  = bcd[3:0] + 4'd3;
      if (bcd[7:4] >= 4'd5)  bcd[7:4]  = bcd[7:4] + 4'd3;
      if (bcd[11:8] >= 4'd5) bcd[11:8] = bcd[11:8] + 4'd3;
      bcd = {bcd[10:0], bin[i]};
    end
    return bcd;
  endfunction

endpackage

>>> sv/jjytce_chan_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jjy time-code encoder channel
// valid/ready channel carrying one payload item per request
// ----------------------------------------------------------------------------
interface jjytce_chan_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> sv/jjy_time_code_frame_encoder_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jjy time-code frame encoder
// turns one calendar minute into the 60 symbols of its jjy frame
// ----------------------------------------------------------------------------
//  channel   | dir | request payload
//  ----------+-----+---------------------------------------------------------
//  in_chan   | in  | cal_year, cal_month, cal_day, clock_hour, clock_minute
//  out_chan  | out | symbol, second_index, high_time_ms, frame_last
//
//  each minute gives 60 result requests, one per cycle while out_chan is ready,
//  so the symbol walker in the back sets the rate at which minutes are taken
//  a frame is registered at every front pipeline stage before it reaches the queue
//  reset is synchronous and active low; there is no clearing pass
//  either side may stall on its own: the queue and the output register decouple them
// ----------------------------------------------------------------------------
module jjy_time_code_frame_encoder_top #(
  parameter int QUEUE_DEPTH = 2
) (
  input logic           clk,
  input logic           rst_n,
  jjytce_chan_if.sink   in_chan,
  jjytce_chan_if.source out_chan
);
  import jjytce_pkg::*;

  // front to queue and queue to back
  q_wr_t q_wr;
  q_rd_t q_rd;
  logic  q_full;
  logic  q_pop;

  // front: calendar arithmetic and frame bit layout, one minute per cycle while the queue is not full
  jjytce_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_chan.ready),
    .in_item  (in_chan.data),
    .q_wr     (q_wr),
    .q_full   (q_full)
  );

  // queue: holds finished frames while the back is still walking one
  jjytce_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_wr   (q_wr),
    .q_full (q_full),
    .q_pop  (q_pop),
    .q_rd   (q_rd)
  );

  // back: one symbol per cycle into the output register while it is free, pops at second 59
  jjytce_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_rd      (q_rd),
    .q_pop     (q_pop),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .out_item  (out_chan.data)
  );

endmodule

>>> sv/jjytce_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jjy time-code encoder front
// five-stage pipeline: century, remainders, julian day, day of year, weekday and frame bits
// ----------------------------------------------------------------------------
module jjytce_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  jjytce_pkg::in_item_t in_item,
  output jjytce_pkg::q_wr_t  q_wr,
  input  logic               q_full
);
  import jjytce_pkg::*;

  localparam int RECIP_100  = 5243;  // 2^19 / 100 rounded up
  localparam int RECIP_SH   = 19;
  localparam int DAYS_CENT4 = 146097;
  localparam int DAYS_YEAR4 = 1461;
  localparam int JDN_OFFSET = 32045;
  localparam int JAN_TERM   = 306;

  typedef struct packed {
    logic [2:0] mt;
    logic [3:0] mu;
    logic [1:0] ht;
    logic [3:0] hu;
  } tod_dig_t;

  typedef struct packed {
    logic [14:0] ya;
    logic [14:0] yj;
    logic [13:0] year;
    logic [7:0]  cy;
    logic [7:0]  cj;
    logic [7:0]  cyr;
    logic [8:0]  mterm;
    logic [4:0]  day;
    tod_dig_t    tod;
  } s1_t;

  typedef struct packed {
    logic [7:0] cy;
    logic [7:0] cj;
    logic [6:0] ry;
    logic [6:0] rj;
    logic [6:0] yyr;
    logic [8:0] mterm;
    logic [4:0] day;
    tod_dig_t   tod;
  } s2_t;

  typedef struct packed {
    logic [23:0] jp1;
    logic [23:0] jan;
    logic [3:0]  yt;
    logic [3:0]  yu;
    tod_dig_t    tod;
  } s3_t;

  typedef struct packed {
    logic [1:0] dh;
    logic [3:0] dt;
    logic [3:0] du;
    logic [5:0] osum;
    logic [3:0] yt;
    logic [3:0] yu;
    tod_dig_t   tod;
  } s4_t;

  function automatic logic [3:0] rev4(input logic [3:0] d);
    return {d[0], d[1], d[2], d[3]};
  endfunction

  logic [4:0] vld_r, vld_nxt, adv;
  s1_t    s1_r, s1_nxt;
  s2_t    s2_r, s2_nxt;
  s3_t    s3_r, s3_nxt;
  s4_t    s4_r, s4_nxt;
  frame_t frame_r, frame_nxt;

  // stage k moves when it is empty or its successor moves
  always_comb begin
    adv[4] = !vld_r[4] || !q_full;
    for (int k = 3; k >= 0; k--) begin
      adv[k] = !vld_r[k] || adv[k+1];
    end
    vld_nxt[0] = adv[0] ? in_valid : vld_r[0];
    for (int k = 1; k < 5; k++) begin
      vld_nxt[k] = adv[k] ? vld_r[k-1] : vld_r[k];
    end
  end

  assign in_ready  = adv[0];
  assign q_wr.push = vld_r[4];
  assign q_wr.bits = frame_r;

  // stage 1: march-based year and month, century by reciprocal
  always_comb begin
    logic        early;
    logic [27:0] py, pj, pr;
    logic [11:0] mb, hb;
    early = in_item.cal_month < 4'd3;
    s1_nxt.year = in_item.cal_year;
    s1_nxt.yj   = 15'(in_item.cal_year) + 15'd4799;
    s1_nxt.ya   = early ? s1_nxt.yj : 15'(in_item.cal_year) + 15'd4800;
    py = 28'(s1_nxt.ya) * 28'(RECIP_100);
    pj = 28'(s1_nxt.yj) * 28'(RECIP_100);
    pr = 28'(in_item.cal_year) * 28'(RECIP_100);
    s1_nxt.cy  = py[RECIP_SH +: 8];
    s1_nxt.cj  = pj[RECIP_SH +: 8];
    s1_nxt.cyr = pr[RECIP_SH +: 8];
    s1_nxt.mterm = month_term(early ? in_item.cal_month + 4'd9 : in_item.cal_month - 4'd3);
    s1_nxt.day = in_item.cal_day;
    mb = bin_to_bcd(9'(in_item.clock_minute));
    hb = bin_to_bcd(9'(in_item.clock_hour));
    s1_nxt.tod.mt = mb[6:4];
    s1_nxt.tod.mu = mb[3:0];
    s1_nxt.tod.ht = hb[5:4];
    s1_nxt.tod.hu = hb[3:0];
  end

  // stage 2: remainders modulo 100
  always_comb begin
    logic [14:0] ry, rj, yr;
    ry = s1_r.ya - 15'(s1_r.cy) * 15'd100;
    rj = s1_r.yj - 15'(s1_r.cj) * 15'd100;
    yr = 15'(s1_r.year) - 15'(s1_r.cyr) * 15'd100;
    s2_nxt.cy    = s1_r.cy;
    s2_nxt.cj    = s1_r.cj;
    s2_nxt.ry    = ry[6:0];
    s2_nxt.rj    = rj[6:0];
    s2_nxt.yyr   = yr[6:0];
    s2_nxt.mterm = s1_r.mterm;
    s2_nxt.day   = s1_r.day;
    s2_nxt.tod   = s1_r.tod;
  end

  // stage 3: julian day plus one, and julian day of january 1st
  always_comb begin
    logic [25:0] cpy, cpj;
    logic [17:0] rpy, rpj;
    logic [11:0] yb;
    cpy = 26'(s2_r.cy) * 26'(DAYS_CENT4);
    cpj = 26'(s2_r.cj) * 26'(DAYS_CENT4);
    rpy = 18'(s2_r.ry) * 18'(DAYS_YEAR4);
    rpj = 18'(s2_r.rj) * 18'(DAYS_YEAR4);
    s3_nxt.jp1 = cpy[25:2] + 24'(rpy[17:2]) + 24'(s2_r.mterm) + 24'(s2_r.day)
                 - 24'(JDN_OFFSET - 1);
    s3_nxt.jan = cpj[25:2] + 24'(rpj[17:2]) + 24'(JAN_TERM + 1) - 24'(JDN_OFFSET);
    yb = bin_to_bcd(9'(s2_r.yyr));
    s3_nxt.yt  = yb[7:4];
    s3_nxt.yu  = yb[3:0];
    s3_nxt.tod = s2_r.tod;
  end

  // stage 4: day of year clamped at zero, octal digit sum for mod 7
  always_comb begin
    logic [24:0] diff;
    logic [8:0]  doy;
    logic [11:0] db;
    diff = {1'b0, s3_r.jp1} - {1'b0, s3_r.jan};
    doy  = diff[24] ? 9'd0 : diff[8:0];
    db   = bin_to_bcd(doy);
    s4_nxt.dh = db[9:8];
    s4_nxt.dt = db[7:4];
    s4_nxt.du = db[3:0];
    s4_nxt.osum = '0;
    for (int k = 0; k < 8; k++) begin
      s4_nxt.osum = s4_nxt.osum + 6'(s3_r.jp1[3*k +: 3]);
    end
    s4_nxt.yt  = s3_r.yt;
    s4_nxt.yu  = s3_r.yu;
    s4_nxt.tod = s3_r.tod;
  end

  // stage 5: weekday fold and frame bit layout
  always_comb begin
    logic [3:0] fold;
    logic [2:0] wd;
    fold = 4'(s4_r.osum[5:3]) + 4'(s4_r.osum[2:0]);
    wd   = (fold >= 4'd7) ? 3'(fold - 4'd7) : fold[2:0];
    frame_nxt = '0;
    frame_nxt[3:1]   = {s4_r.tod.mt[0], s4_r.tod.mt[1], s4_r.tod.mt[2]};
    frame_nxt[8:5]   = rev4(s4_r.tod.mu);
    frame_nxt[13:12] = {s4_r.tod.ht[0], s4_r.tod.ht[1]};
    frame_nxt[18:15] = rev4(s4_r.tod.hu);
    frame_nxt[23:22] = {s4_r.dh[0], s4_r.dh[1]};
    frame_nxt[28:25] = rev4(s4_r.dt);
    frame_nxt[33:30] = rev4(s4_r.du);
    frame_nxt[36]    = ^{s4_r.tod.ht, s4_r.tod.hu};
    frame_nxt[37]    = ^{s4_r.tod.mt, s4_r.tod.mu};
    frame_nxt[44:41] = rev4(s4_r.yt);
    frame_nxt[48:45] = rev4(s4_r.yu);
    frame_nxt[52:50] = {wd[0], wd[1], wd[2]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv[0]) s1_r    <= s1_nxt;
    if (adv[1]) s2_r    <= s2_nxt;
    if (adv[2]) s3_r    <= s3_nxt;
    if (adv[3]) s4_r    <= s4_nxt;
    if (adv[4]) frame_r <= frame_nxt;
  end

endmodule

>>> sv/jjytce_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jjy time-code encoder frame queue
// small register fifo of frame bit vectors between front and back
// ----------------------------------------------------------------------------
module jjytce_queue #(
  parameter int DEPTH = 2
) (
  input  logic              clk,
  input  logic              rst_n,
  input  jjytce_pkg::q_wr_t q_wr,
  output logic              q_full,
  input  logic              q_pop,
  output jjytce_pkg::q_rd_t q_rd
);
  import jjytce_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  frame_t           mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             push_ok, pop_ok;

  assign q_full     = cnt_r == CNT_W'(DEPTH);
  assign q_rd.avail = cnt_r != '0;
  assign q_rd.bits  = mem_r[rd_ptr_r];

  assign push_ok = q_wr.push && !q_full;
  assign pop_ok  = q_pop && q_rd.avail;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push_ok) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop_ok) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push_ok && !pop_ok) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop_ok && !push_ok) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      mem_r[wr_ptr_r] <= q_wr.bits;
    end
  end

endmodule

>>> sv/jjytce_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jjy time-code encoder back
// walks the head frame one second per cycle, while the output is free, into a registered output
// ----------------------------------------------------------------------------
module jjytce_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  jjytce_pkg::q_rd_t     q_rd,
  output logic                  q_pop,
  output logic                  out_valid,
  input  logic                  out_ready,
  output jjytce_pkg::out_item_t out_item
);
  import jjytce_pkg::*;

  logic [5:0] sec_r, sec_nxt;
  logic       out_valid_r, out_valid_nxt;
  out_item_t  item_r, item_nxt;
  logic       adv, emit, last;

  assign adv  = !out_valid_r || out_ready;
  assign emit = adv && q_rd.avail;
  assign last = sec_r == LAST_SEC;

  assign q_pop = emit && last;

  always_comb begin
    sec_nxt       = sec_r;
    out_valid_nxt = out_valid_r;
    if (adv) begin
      out_valid_nxt = q_rd.avail;
    end
    if (emit) begin
      sec_nxt = last ? '0 : sec_r + 6'd1;
    end
  end

  always_comb begin
    item_nxt.second_index = sec_r;
    item_nxt.frame_last   = last;
    if (MARKER_MASK[sec_r]) begin
      item_nxt.symbol       = SYM_MARKER;
      item_nxt.high_time_ms = HT_MARKER;
    end else if (q_rd.bits[sec_r]) begin
      item_nxt.symbol       = SYM_ONE;
      item_nxt.high_time_ms = HT_ONE;
    end else begin
      item_nxt.symbol       = SYM_ZERO;
      item_nxt.high_time_ms = HT_ZERO;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sec_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      sec_r       <= sec_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      item_r <= item_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = item_r;

endmodule

>>> sv/jjytce_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jjy time-code encoder port checker
// watches the result channel for frame order and symbol coding
// ----------------------------------------------------------------------------
`include "jjy_time_code_frame_encoder_top_macros.svh"

module jjytce_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] out_symbol,
  input logic [5:0] out_second_index,
  input logic [9:0] out_high_time_ms,
  input logic       out_frame_last
);
  import jjytce_pkg::*;

  logic [5:0] exp_idx_r, exp_idx_nxt;

  always_comb begin
    exp_idx_nxt = exp_idx_r;
    if (out_valid && out_ready) begin
      exp_idx_nxt = (exp_idx_r == LAST_SEC) ? '0 : exp_idx_r + 6'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_idx_r <= '0;
    end else begin
      exp_idx_r <= exp_idx_nxt;
    end
  end

  `JJYTCE_ASSERT_ALWAYS(a_reset_quiet, !rst_n |=> !out_valid, "result request right after reset")
  `JJYTCE_ASSERT_ON(a_second_order, out_valid |-> out_second_index == exp_idx_r, "second out of order")
  `JJYTCE_ASSERT_ON(a_last_flag, out_valid |-> out_frame_last == (out_second_index == LAST_SEC), "frame_last misplaced")
  `JJYTCE_ASSERT_ON(a_symbol_time, out_valid |-> (out_symbol == SYM_MARKER && out_high_time_ms == HT_MARKER) || (out_symbol == SYM_ZERO && out_high_time_ms == HT_ZERO) || (out_symbol == SYM_ONE && out_high_time_ms == HT_ONE), "symbol and high time disagree")
  `JJYTCE_ASSERT_ON(a_marker_seat, out_valid && (out_second_index == 6'd0 || out_second_index == 6'd9 || out_second_index == 6'd19 || out_second_index == 6'd29 || out_second_index == 6'd39 || out_second_index == 6'd49 || out_second_index == LAST_SEC) |-> out_symbol == SYM_MARKER, "missing marker")

endmodule

bind jjy_time_code_frame_encoder_top jjytce_checker u_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_chan.valid),
  .out_ready        (out_chan.ready),
  .out_symbol       (out_chan.data.symbol),
  .out_second_index (out_chan.data.second_index),
  .out_high_time_ms (out_chan.data.high_time_ms),
  .out_frame_last   (out_chan.data.frame_last)
);

>>> bench/jjy_time_code_frame_encoder_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jjy time-code frame encoder testbench
// drives calendar minutes into the encoder and compares every emitted symbol
// against a frame built locally from the julian day number, under random
// back-pressure and sender gaps
// ----------------------------------------------------------------------------

// holds the symbols each accepted minute should produce, oldest first
class frame_scoreboard;
  jjytce_pkg::out_item_t symbols_due[$];
  int mismatches;

  function new();
    mismatches = 0;
  endfunction

  // chronological julian day number, proleptic gregorian
  function longint julian_day(longint y, longint m, longint d);
    longint c;
    if (m < 3) begin
      m = m + 9;
      y = y - 1;
    end else begin
      m = m - 3;
    end
    y = y + 4800;
    c = y / 100;
    return c * 146097 / 4 + (y - c * 100) * 1461 / 4 + (153 * m + 2) / 5 + d - 32045;
  endfunction

  // builds the whole 60-second frame for one minute
  function void note_minute(jjytce_pkg::in_item_t m);
    logic [59:0]           frame_bits;
    longint                jdn;
    longint                doy_s;
    longint                doy;
    longint                wd;
    longint                yy;
    logic [3:0]            tens;
    logic [3:0]            units;
    logic [3:0]            hundreds;
    jjytce_pkg::out_item_t sym;

    frame_bits = '0;
    jdn   = julian_day(longint'(m.cal_year), longint'(m.cal_month), longint'(m.cal_day));
    doy_s = jdn - julian_day(longint'(m.cal_year), 1, 1) + 1;
    doy   = (doy_s < 0) ? 0 : doy_s;
    wd    = (jdn + 1) % 7;
    yy    = longint'(m.cal_year) % 100;

    tens  = 4'(m.clock_minute / 10);
    units = 4'(m.clock_minute % 10);
    {frame_bits[1], frame_bits[2], frame_bits[3]} = tens[2:0];
    {frame_bits[5], frame_bits[6], frame_bits[7], frame_bits[8]} = units;

    tens  = 4'(m.clock_hour / 10);
    units = 4'(m.clock_hour % 10);
    {frame_bits[12], frame_bits[13]} = tens[1:0];
    {frame_bits[15], frame_bits[16], frame_bits[17], frame_bits[18]} = units;

    hundreds = 4'(doy / 100);
    tens     = 4'((doy / 10) % 10);
    units    = 4'(doy % 10);
    {frame_bits[22], frame_bits[23]} = hundreds[1:0];
    {frame_bits[25], frame_bits[26], frame_bits[27], frame_bits[28]} = tens;
    {frame_bits[30], frame_bits[31], frame_bits[32], frame_bits[33]} = units;

    tens  = 4'(yy / 10);
    units = 4'(yy % 10);
    {frame_bits[41], frame_bits[42], frame_bits[43], frame_bits[44]} = tens;
    {frame_bits[45], frame_bits[46], frame_bits[47], frame_bits[48]} = units;

    units = 4'(wd);
    {frame_bits[50], frame_bits[51], frame_bits[52]} = units[2:0];

    frame_bits[36] = ^frame_bits[18:12];
    frame_bits[37] = ^frame_bits[8:1];

    for (int s = 0; s < jjytce_pkg::FRAME_LEN; s++) begin
      if (s == 0 || s % 10 == 9) begin
        sym.symbol       = jjytce_pkg::SYM_MARKER;
        sym.high_time_ms = jjytce_pkg::HT_MARKER;
      end else if (frame_bits[s]) begin
        sym.symbol       = jjytce_pkg::SYM_ONE;
        sym.high_time_ms = jjytce_pkg::HT_ONE;
      end else begin
        sym.symbol       = jjytce_pkg::SYM_ZERO;
        sym.high_time_ms = jjytce_pkg::HT_ZERO;
      end
      sym.second_index = 6'(s);
      sym.frame_last   = (6'(s) == jjytce_pkg::LAST_SEC);
      symbols_due = {symbols_due, sym};
    end
  endfunction

  function void check_symbol(jjytce_pkg::out_item_t got);
    jjytce_pkg::out_item_t want;
    if (symbols_due.size() == 0) begin
      $error("unexpected symbol request: symbol %0d second %0d",
             got.symbol, got.second_index);
      mismatches++;
      return;
    end
    want = symbols_due.pop_front();
    if (got.symbol !== want.symbol) begin
      $error("symbol: expected %0d, actual %0d", want.symbol, got.symbol);
      mismatches++;
    end
    if (got.second_index !== want.second_index) begin
      $error("second_index: expected %0d, actual %0d", want.second_index, got.second_index);
      mismatches++;
    end
    if (got.high_time_ms !== want.high_time_ms) begin
      $error("high_time_ms: expected %0d, actual %0d", want.high_time_ms, got.high_time_ms);
      mismatches++;
    end
    if (got.frame_last !== want.frame_last) begin
      $error("frame_last: expected %0d, actual %0d", want.frame_last, got.frame_last);
      mismatches++;
    end
  endfunction

  function int pending();
    return symbols_due.size();
  endfunction
endclass

module jjy_time_code_frame_encoder_top_test;
  import jjytce_pkg::*;

  // generous ceiling on the whole run, far above the slowest legal run
  localparam int CYCLE_LIMIT = 1000000;
  // front pipeline depth plus a margin, waited out before the verdict
  localparam int TAIL_CYCLES = 40;
  localparam int RANDOM_PER_PHASE = 33;

  logic clk;
  logic rst_n;

  jjytce_chan_if #(.payload_t(in_item_t))  in_chan ();
  jjytce_chan_if #(.payload_t(out_item_t)) out_chan ();

  jjy_time_code_frame_encoder_top DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  frame_scoreboard frames;
  int              send_idle_pct;
  int              recv_idle_pct;

  // 2 ns clock
  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // receiver: random back-pressure, one assignment per edge
  always @(posedge clk) begin
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
    end else begin
      out_chan.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // monitor: note accepted minutes first, then check returned symbols,
  // all on values sampled before this edge's updates
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_chan.valid && in_chan.ready) begin
        frames.note_minute(in_chan.data);
      end
      if (out_chan.valid && out_chan.ready) begin
        frames.check_symbol(out_chan.data);
      end
    end
  end

  // watchdog
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("tb: failure");
    $finish;
  end

  // one minute request; valid is left high on acceptance so a back-to-back
  // request never lowers and raises it in the same step
  task automatic send_minute(input int y, input int mo, input int d, input int h,
                             input int mi);
    in_item_t req;
    req.cal_year     = 14'(y);
    req.cal_month    = 4'(mo);
    req.cal_day      = 5'(d);
    req.clock_hour   = 5'(h);
    req.clock_minute = 6'(mi);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_chan.valid <= 1'b0;
      @(posedge clk);
    end
    in_chan.valid <= 1'b1;
    in_chan.data  <= req;
    do @(posedge clk); while (!in_chan.ready);
  endtask

  // mostly well-formed minutes, the rest full-width noise on every field
  task automatic send_random_minutes(input int n);
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(0, 99) < 80) begin
        send_minute($urandom_range(1, 9999), $urandom_range(1, 12), $urandom_range(1, 28),
                    $urandom_range(0, 23), $urandom_range(0, 59));
      end else begin
        send_minute($urandom_range(0, 16383), $urandom_range(0, 15), $urandom_range(0, 31),
                    $urandom_range(0, 31), $urandom_range(0, 63));
      end
    end
  endtask

  // sender holds off until every owed symbol has come back
  task automatic drain_frames();
    in_chan.valid <= 1'b0;
    @(posedge clk);
    while (frames.pending() != 0) @(posedge clk);
  endtask

  initial begin
    frames         = new();
    send_idle_pct  = 24;
    recv_idle_pct  = 87;
    rst_n          = 1'b0;
    in_chan.valid  = 1'b0;
    in_chan.data   = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed minutes: calendar corners, field extremes, odd cases
    send_minute(2024, 2, 29, 12, 34);     // leap day
    send_minute(2000, 12, 31, 23, 59);    // day 366 in a century leap year
    send_minute(1900, 3, 1, 0, 0);        // century that is not leap
    send_minute(1, 1, 1, 0, 0);           // first year
    send_minute(9999, 12, 31, 23, 59);    // last year
    send_minute(16383, 15, 31, 31, 63);   // all ones: huge day of year, wide hour/minute
    send_minute(0, 0, 0, 0, 0);           // all zeros: year 0, negative day of year
    send_minute(2023, 0, 15, 10, 10);     // month 0 folds back into last december
    send_minute(2023, 13, 1, 5, 5);       // month past december
    send_minute(2023, 1, 0, 7, 7);        // day 0 gives day of year 0
    send_minute(2021, 12, 31, 19, 45);    // day 365
    send_minute(2017, 1, 1, 0, 0);        // sunday
    send_minute(2022, 10, 29, 14, 22);    // saturday
    send_minute(2099, 6, 15, 24, 60);     // hour and minute just out of range
    send_minute(2050, 7, 4, 29, 31);      // hour tens of 2 with units 9
    send_minute(1999, 9, 9, 9, 9);
    send_minute(2008, 8, 8, 8, 58);
    send_minute(1600, 2, 29, 1, 1);
    send_minute(2024, 11, 11, 21, 39);
    send_minute(4, 14, 30, 16, 47);

    send_random_minutes(RANDOM_PER_PHASE);
    drain_frames();

    // sender slow, receiver eager
    send_idle_pct = 87;
    recv_idle_pct = 24;
    send_random_minutes(RANDOM_PER_PHASE);
    drain_frames();

    // full rate on both sides
    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_random_minutes(RANDOM_PER_PHASE);
    drain_frames();

    repeat (TAIL_CYCLES) @(posedge clk);
    if (frames.mismatches == 0 && frames.pending() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
